>>> src/xmodem_checksum_receiver_macros.svh
// assertion macros for the xmodem checksum receiver
// used by the top level; needs nothing else
`ifndef XMODEM_CHECKSUM_RECEIVER_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_MACROS_SVH

// implication checked in the same cycle, muted during reset
`define XCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xcr check failed");

// implication checked in the next cycle, muted during reset
`define XCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xcr check failed");

`endif

>>> src/xcr_pkg.sv
// shared types and constants of the xmodem checksum receiver
// no dependencies
package xcr_pkg;

   localparam int DATA_BYTES = 128;
   localparam int WORD_BYTES = 8;
   localparam int WORDS      = DATA_BYTES / WORD_BYTES;
   localparam int WORD_W     = 8 * WORD_BYTES;
   localparam int WADDR_W    = $clog2(WORDS);
   localparam int LANE_W     = $clog2(WORD_BYTES);
   localparam int DIDX_W     = $clog2(DATA_BYTES);
   localparam int CSR_IDX_W  = 1;

   localparam logic [7:0] SYM_SOH  = 8'h01;
   localparam logic [7:0] SYM_ACK  = 8'h06;
   localparam logic [7:0] SYM_NAK  = 8'h15;
   localparam logic [7:0] SYM_EOT  = 8'h04;
   localparam logic [7:0] CPL_MASK = 8'hFF;

   localparam logic [7:0] POS_DATA = 8'd3;
   localparam logic [7:0] POS_SUM  = 8'd131;

   localparam logic [31:0] TIMEOUT_RESET   = 32'd4000000;
   localparam logic [31:0] LOAD_BASE_RESET = 32'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT   = 1'b0,
      CSR_LOAD_BASE = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_EXEC  = 2'd1,
      ST_DRAIN = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic              reply_valid;
      logic [7:0]        reply_byte;
      logic              write_valid;
      logic [31:0]       write_addr;
      logic [WORD_W-1:0] write_data;
      logic              jump;
      logic              last;
   } rsp_word_type;

endpackage

>>> src/xcr_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module xcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> src/xcr_ctl.sv
// packet parser, silence counter and drain sequencer
// depends on xcr_pkg; drives the packet ram
module xcr_ctl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_kind,
   input  logic [7:0]                     req_rx_byte,
   output logic                           req_stall,
   input  logic [31:0]                    timeout,
   input  logic                           out_free,
   output logic                           out_load,
   output xcr_pkg::rsp_word_type          out_word,
   output logic                           ram_we,
   output logic [xcr_pkg::WADDR_W-1:0]    ram_waddr,
   output logic [xcr_pkg::WORD_W-1:0]     ram_wdata,
   output logic [xcr_pkg::WADDR_W-1:0]    ram_raddr,
   input  logic [xcr_pkg::WORD_W-1:0]     ram_rdata
);
   import xcr_pkg::*;

   ctl_state_type        state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic [7:0]           byte_ff, byte_in;
   logic [7:0]           pos_ff, pos_in;
   logic [7:0]           blk_ff, blk_in;
   logic [7:0]           sum_ff, sum_in;
   logic [WORD_W-1:0]    asm_ff, asm_in;
   logic [31:0]          wp_ff, wp_in;
   logic [31:0]          sc_ff, sc_in;
   logic                 fin_ff, fin_in;
   logic [WADDR_W-1:0]   cnt_ff, cnt_in;

   logic [7:0]           data_idx;
   logic [DIDX_W-1:0]    didx;
   logic [LANE_W-1:0]    lane;
   logic                 last_word;
   rsp_word_type         nak_word;
   rsp_word_type         ack_word;

   assign data_idx  = pos_ff - POS_DATA;
   assign didx      = data_idx[DIDX_W-1:0];
   assign lane      = didx[LANE_W-1:0];
   assign last_word = (cnt_ff == WADDR_W'(WORDS - 1));
   assign ram_waddr = didx[DIDX_W-1:LANE_W];
   assign ram_wdata = {byte_ff, asm_ff[WORD_W-9:0]};
   assign ram_raddr = cnt_in;

   always_comb begin
      nak_word             = '0;
      nak_word.reply_valid = 1'b1;
      nak_word.reply_byte  = SYM_NAK;
      nak_word.last        = 1'b1;
      ack_word             = nak_word;
      ack_word.reply_byte  = SYM_ACK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         blk_ff   <= 8'd1;
         sum_ff   <= '0;
         wp_ff    <= LOAD_BASE_RESET;
         sc_ff    <= '0;
         fin_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         blk_ff   <= blk_in;
         sum_ff   <= sum_in;
         wp_ff    <= wp_in;
         sc_ff    <= sc_in;
         fin_ff   <= fin_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      asm_ff  <= asm_in;
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      pos_in    = pos_ff;
      blk_in    = blk_ff;
      sum_in    = sum_ff;
      asm_in    = asm_ff;
      wp_in     = wp_ff;
      sc_in     = sc_ff;
      fin_in    = fin_ff;
      cnt_in    = cnt_ff;
      req_stall = 1'b1;
      out_load  = 1'b0;
      out_word  = '0;
      ram_we    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            // after eot words are taken and dropped
            if (req_valid && !fin_ff) begin
               kind_in  = kind_type'(req_kind);
               byte_in  = req_rx_byte;
               sc_in    = (kind_type'(req_kind) == KIND_TICK) ? sc_ff + 32'd1 : '0;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (kind_ff == KIND_TICK) begin
                  if (sc_ff >= timeout) begin
                     sc_in    = sc_ff - timeout;
                     out_load = 1'b1;
                     out_word = nak_word;
                  end
               end else begin
                  priority if (pos_ff == 8'd0) begin
                     priority if (byte_ff == SYM_EOT) begin
                        fin_in        = 1'b1;
                        out_load      = 1'b1;
                        out_word      = ack_word;
                        out_word.jump = 1'b1;
                     end else if (byte_ff == SYM_SOH) begin
                        sum_in = byte_ff;
                        pos_in = 8'd1;
                     end else begin
                        out_load = 1'b1;
                        out_word = nak_word;
                     end
                  end else if (pos_ff == 8'd1 || pos_ff == 8'd2) begin
                     if (byte_ff == ((pos_ff == 8'd1) ? blk_ff : (CPL_MASK ^ blk_ff))) begin
                        sum_in = sum_ff + byte_ff;
                        pos_in = pos_ff + 8'd1;
                     end else begin
                        pos_in   = '0;
                        out_load = 1'b1;
                        out_word = nak_word;
                     end
                  end else if (pos_ff < POS_SUM) begin
                     // gather a word, write it once its top byte lands
                     asm_in[{lane, 3'b000} +: 8] = byte_ff;
                     ram_we = (lane == LANE_W'(WORD_BYTES - 1));
                     sum_in = sum_ff + byte_ff;
                     pos_in = pos_ff + 8'd1;
                  end else begin
                     pos_in = '0;
                     if (byte_ff != sum_ff) begin
                        out_load = 1'b1;
                        out_word = nak_word;
                     end else begin
                        cnt_in   = '0;
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end
         end

         ST_DRAIN: begin
            // ram data at this cycle belongs to cnt_ff
            if (out_free) begin
               out_load             = 1'b1;
               out_word.write_valid = 1'b1;
               out_word.write_addr  = wp_ff + 32'({cnt_ff, {LANE_W{1'b0}}});
               out_word.write_data  = ram_rdata;
               out_word.reply_valid = last_word;
               out_word.reply_byte  = last_word ? SYM_ACK : 8'h00;
               out_word.last        = last_word;
               cnt_in               = cnt_ff + WADDR_W'(1);
               if (last_word) begin
                  wp_in    = wp_ff + 32'(DATA_BYTES);
                  blk_in   = blk_ff + 8'd1;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/xmodem_checksum_receiver.sv
// top level of the xmodem checksum receiver: csr, packet ram, result register
// depends on xcr_pkg, xcr_ram, xcr_ctl and the assertion macro header
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------------------
//  req     | in        | req_valid/req_stall | kind, rx_byte
//  rsp     | out       | rsp_valid/rsp_stall | reply, write addr/data, jump, last
//  csr     | in        | csr_write_en        | csr_index, csr_wdata (no read-back)
//
// a byte or tick word is accepted in ST_IDLE, then handled in ST_EXEC
// a good checksum byte starts a drain of sixteen 64-bit words, one word per cycle off
// the single read port of the packet ram; rsp_stall holds up any of these steps
// reset is synchronous and clears all control state; packet ram needs no clearing
// the result register lets a new req word be taken while a result waits
`include "xmodem_checksum_receiver_macros.svh"

module xmodem_checksum_receiver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_reply_valid,
   output logic [7:0]                       rsp_reply_byte,
   output logic                             rsp_write_valid,
   output logic [31:0]                      rsp_write_addr,
   output logic [xcr_pkg::WORD_W-1:0]       rsp_write_data,
   output logic                             rsp_jump,
   output logic                             rsp_last,
   input  logic                             csr_write_en,
   input  logic [xcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_wdata
);
   import xcr_pkg::*;

   logic [31:0]         timeout_ff, timeout_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                out_free;
   logic                out_load;
   rsp_word_type        out_word;
   logic                ram_we;
   logic [WADDR_W-1:0]  ram_waddr;
   logic [WORD_W-1:0]   ram_wdata;
   logic [WADDR_W-1:0]  ram_raddr;
   logic [WORD_W-1:0]   ram_rdata;

   // csr: timeout is live; the write pointer is loaded from the default base
   // at reset, and a load base write is dropped, so a written base never lands
   always_comb begin
      timeout_in = timeout_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIMEOUT:   timeout_in = csr_wdata;
            CSR_LOAD_BASE: timeout_in = timeout_ff;
            default:       timeout_in = timeout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register, free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = out_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_valid = rsp_word_ff.reply_valid;
   assign rsp_reply_byte  = rsp_word_ff.reply_byte;
   assign rsp_write_valid = rsp_word_ff.write_valid;
   assign rsp_write_addr  = rsp_word_ff.write_addr;
   assign rsp_write_data  = rsp_word_ff.write_data;
   assign rsp_jump        = rsp_word_ff.jump;
   assign rsp_last        = rsp_word_ff.last;

   // packet data, one 64-bit word per ram entry
   xcr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   xcr_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .timeout     (timeout_ff),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_word    (out_word),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata)
   );

   // a pending result is never overwritten
   `XCR_ASSERT_NOW(a_no_overwrite, clock, reset, out_load, out_free)
   // the final write of a packet carries ack and stays word aligned
   `XCR_ASSERT_NOW(a_last_write_ack, clock, reset,
      out_load && out_word.write_valid && out_word.last,
      out_word.reply_byte == SYM_ACK && out_word.write_addr[LANE_W-1:0] == '0)
   // a jump result is a lone ack with no data
   `XCR_ASSERT_NOW(a_jump_alone, clock, reset, out_load && out_word.jump,
      !out_word.write_valid && out_word.last && out_word.reply_byte == SYM_ACK)

endmodule
